// ===== rtl/core/prefetch_staging_tag_table_macros.svh =====
// ----------------------------------------------------------------------------
// prefetch_staging_tag_table_macros
// Assertion helpers for the staging tag table.
// ----------------------------------------------------------------------------
`ifndef PREFETCH_STAGING_TAG_TABLE_MACROS_SVH
`define PREFETCH_STAGING_TAG_TABLE_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define PSTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check an implication including cycles under reset.
`define PSTT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/core/pstt_pkg.sv =====
// ----------------------------------------------------------------------------
// pstt_pkg
// Shared types and constants of the prefetch staging tag table.
// ----------------------------------------------------------------------------
package pstt_pkg;
  localparam int STAGE_ENTRIES_DEF = 64;
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int OFF_W   = 50;
  localparam int CNT_W   = 32;
  localparam int LAYER_W = 8;
  localparam int EXP_W   = 10;
  localparam logic [OFF_W-1:0] HDR_BYTES = OFF_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef enum logic [2:0] {
    CMD_PREFETCH = 3'd0,
    CMD_LOOKUP   = 3'd1,
    CMD_PROMOTE  = 3'd2,
    CMD_ISSUE    = 3'd3,
    CMD_COMPLETE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LAYER_COUNT = 2'd0,
    REG_EXPERTS     = 2'd1,
    REG_EXPERT_SIZE = 2'd2,
    REG_PACKED      = 2'd3
  } reg_idx_t;

  // Multiply request/response between the sequencer and the shared unit
  typedef struct packed {
    logic        start;
    logic [41:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] prod;
  } mul_rsp_t;
endpackage

// ===== rtl/core/pstt_mul.sv =====
// ----------------------------------------------------------------------------
// pstt_mul
// Shared multiplier: 42x32 product in two 21x32 partial steps, mod 2^50.
// ----------------------------------------------------------------------------
module pstt_mul import pstt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);
  logic        busy;
  logic        step;
  logic [41:0] a;
  logic [31:0] b;
  logic [52:0] part;
  logic [OFF_W-1:0] acc;

  // One partial product per cycle, low half first
  assign part = (step ? {11'd0, a[41:21]} : {11'd0, a[20:0]}) * {21'd0, b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 1'b0;
        a    <= req.a;
        b    <= req.b;
      end else if (busy) begin
        if (!step) begin
          acc  <= part[OFF_W-1:0];
          step <= 1'b1;
        end else begin
          rsp.prod <= acc + {part[28:0], 21'd0};
          rsp.done <= 1'b1;
          busy     <= 1'b0;
        end
      end
    end
  end
endmodule

// ===== rtl/core/prefetch_staging_tag_table.sv =====
// ----------------------------------------------------------------------------
// prefetch_staging_tag_table
// Tag controller for a direct-mapped staging store with a prefetch queue.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: cmd, layer, expert, load_ok
// m_axis    out  tdata: hit, accepted, load_valid, load_slot, load_layer,
//                load_expert, load_offset, queue_level, totals
// cfg       in   cfg_we, cfg_index, cfg_data
// Lookup and promote: key multiply, tag read, compare. Completion: key multiply,
// tag write. Issue: key multiply then offset multiply on the shared two-step
// multiplier (no offset multiply when the key is dropped, no multiply on an empty queue).
// Prefetch scans the waiting keys in turn, none when the queue is full. Unused codes go
// straight to the result. One item at a time; s_axis_tready is low while an
// item is in work or its result waits on m_axis, and rises the cycle after the
// result is taken. Reset is synchronous; the tag valid bits clear at once.
`include "prefetch_staging_tag_table_macros.svh"
module prefetch_staging_tag_table import pstt_pkg::*; #(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [23:0]   s_axis_tdata,   // cmd[2:0] layer[10:3] expert[20:11] load_ok[21]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [183:0]  m_axis_tdata,   // hit accepted load_valid load_slot load_layer
                                        // load_expert load_offset queue_level hit_total
                                        // miss_total done_total
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  localparam int STAGE_ENTRIES = STAGE_ENTRIES_DEF;
  localparam int SW = (STAGE_ENTRIES > 1) ? $clog2(STAGE_ENTRIES) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_KEY, S_KEYW, S_TAG, S_OFF, S_OFFW, S_OUT
  } state_t;

  // configuration
  logic [8:0]  layer_count;
  logic [10:0] experts_per_layer;
  logic [31:0] expert_bytes;
  logic        packed_mode;

  // queue and tags
  logic [LAYER_W-1:0] q_layer [QUEUE_DEPTH];
  logic [EXP_W-1:0]   q_expert[QUEUE_DEPTH];
  logic [QW-1:0]      head;
  logic [FW-1:0]      fill;
  logic [STAGE_ENTRIES-1:0] e_valid;
  logic [LAYER_W-1:0] e_layer [STAGE_ENTRIES];
  logic [EXP_W-1:0]   e_expert[STAGE_ENTRIES];
  logic [CNT_W-1:0]   hits, misses, dones;

  state_t state;
  cmd_t   cmd;
  logic [2:0] cmd_raw;
  logic [LAYER_W-1:0] ly;
  logic [EXP_W-1:0]   ex;
  logic ok;
  logic [FW-1:0] scan_i;
  logic [QW-1:0] scan_q;
  logic [41:0]   key;
  logic [SW-1:0] slot;
  logic [LAYER_W-1:0] t_layer;
  logic [EXP_W-1:0]   t_expert;
  logic t_valid;

  // result fields
  logic r_hit, r_acc, r_lv;
  logic [5:0] r_slot;
  logic [OFF_W-1:0] r_off;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic [FW:0]   scan_sum;
  logic [QW-1:0] head_inc;

  pstt_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  assign cmd     = cmd_t'(cmd_raw);
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  // wrap the queue positions by compare and subtract
  assign scan_sum = (FW+1)'(head) + (FW+1)'(scan_i);
  assign scan_q   = (scan_sum >= (FW+1)'(QUEUE_DEPTH)) ?
                    QW'(scan_sum - (FW+1)'(QUEUE_DEPTH)) : QW'(scan_sum);
  assign head_inc = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
  assign slot     = key[SW-1:0];

  // drive the multiplier
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = {34'd0, ly};
    mreq.b     = {21'd0, experts_per_layer};
    if (state == S_KEY) begin
      mreq.start = 1'b1;
    end else if (state == S_OFF) begin
      mreq.start = 1'b1;
      mreq.a     = packed_mode ? key : {32'd0, ex};
      mreq.b     = expert_bytes;
    end
  end

  assign m_axis_tdata = {6'd0, dones, misses, hits, 5'(fill),
                         r_off, ex & {EXP_W{r_lv}}, ly & {LAYER_W{r_lv}},
                         r_slot, r_lv, r_acc, r_hit};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      head <= '0;
      fill <= '0;
      e_valid <= '0;
      hits <= '0;
      misses <= '0;
      dones <= '0;
      layer_count <= 9'd48;
      experts_per_layer <= 11'd256;
      expert_bytes <= 32'd5308416;
      packed_mode <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_LAYER_COUNT: layer_count <= cfg_data[8:0];
          REG_EXPERTS:     experts_per_layer <= cfg_data[10:0];
          REG_EXPERT_SIZE: expert_bytes <= cfg_data;
          REG_PACKED:      packed_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            cmd_raw <= s_axis_tdata[2:0];
            ok <= s_axis_tdata[21];
            r_hit <= 1'b0; r_acc <= 1'b0; r_lv <= 1'b0;
            r_slot <= '0; r_off <= '0;
            scan_i <= '0;
            // issue takes its key from the queue head
            if (s_axis_tdata[2:0] == CMD_ISSUE && fill != '0) begin
              ly <= q_layer[head];
              ex <= q_expert[head];
              head <= head_inc;
              fill <= fill - FW'(1);
            end else begin
              ly <= s_axis_tdata[10:3];
              ex <= s_axis_tdata[20:11];
            end
            unique case (s_axis_tdata[2:0])
              CMD_PREFETCH: state <= S_SCAN;
              CMD_LOOKUP, CMD_PROMOTE, CMD_COMPLETE: state <= S_KEY;
              CMD_ISSUE: state <= (fill == '0) ? S_OUT : S_KEY;
              default: state <= S_OUT;
            endcase
          end
        end
        // walk the waiting keys one per cycle
        S_SCAN: begin
          if (fill == FW'(QUEUE_DEPTH)) state <= S_OUT;
          else if (scan_i == fill) begin
            q_layer[scan_q]  <= ly;
            q_expert[scan_q] <= ex;
            fill  <= fill + FW'(1);
            r_acc <= 1'b1;
            state <= S_OUT;
          end else if (q_layer[scan_q] == ly && q_expert[scan_q] == ex) begin
            state <= S_OUT;
          end else scan_i <= scan_i + FW'(1);
        end
        S_KEY: state <= S_KEYW;
        S_KEYW: if (mrsp.done) begin
          key <= mrsp.prod[41:0] + {32'd0, ex};
          state <= S_TAG;
        end
        // read the tags of the slot; a completion also writes them
        S_TAG: begin
          t_valid  <= e_valid[slot];
          t_layer  <= e_layer[slot];
          t_expert <= e_expert[slot];
          if (cmd == CMD_ISSUE) r_slot <= 6'(slot);
          if (cmd == CMD_COMPLETE) begin
            e_valid[slot] <= ok;
            if (ok) begin
              e_layer[slot]  <= ly;
              e_expert[slot] <= ex;
              if (dones != CNT_MAX) dones <= dones + 1'b1;
            end
            state <= S_OUT;
          end else state <= S_OFF;
        end
        S_OFF: begin
          if (cmd == CMD_ISSUE) begin
            if ((t_valid && t_layer == ly && t_expert == ex) ||
                (!packed_mode && {1'b0, ly} >= layer_count)) begin
              r_slot <= '0;
              state <= S_OUT;
            end else state <= S_OFFW;
          end else begin
            if (t_valid && t_layer == ly && t_expert == ex) begin
              r_hit <= 1'b1;
              if (hits != CNT_MAX) hits <= hits + 1'b1;
            end else if (cmd == CMD_LOOKUP && misses != CNT_MAX) misses <= misses + 1'b1;
            r_slot <= '0;
            state <= S_OUT;
          end
        end
        S_OFFW: if (mrsp.done) begin
          r_off <= packed_mode ? mrsp.prod + HDR_BYTES : mrsp.prod;
          r_lv  <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSTT_ASSERT(a_fill_range, fill <= FW'(QUEUE_DEPTH), "queue fill beyond depth")
  `PSTT_ASSERT(a_no_take_busy, m_axis_tvalid |-> !s_axis_tready, "item taken while result waits")
  `PSTT_ASSERT(a_lv_slot, (m_axis_tvalid && !r_lv) |-> (r_slot == '0 && r_off == '0), "load fields set without load")
  `PSTT_ASSERT_RST(a_rst_idle, $past(rst) |-> !m_axis_tvalid, "result after reset")
endmodule
